FILE: src/pida_pkg.sv
// Package for the pick id allocator: command and status codes, colour tag,
// default sizes. No dependencies.
package pida_pkg;

  localparam int MAX_IDS_DEF     = 256;
  localparam int HANDLE_BITS_DEF = 32;

  // beat field widths
  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int ID_OUT_W = 8;
  localparam int STATUS_W = 2;

  // low bits of a pick code that carry the id
  localparam int CODE_ID_BITS = 24;

  localparam logic [WORD_W-1:0] COLOR_TOP = 32'hFF00_0000;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

FILE: src/pida_ifs.sv
// Request and response channel interfaces for the pick id allocator.
// Depends on pida_pkg for field widths.
interface pida_req_if;
  logic                           valid;
  logic                           ready;
  logic [pida_pkg::CMD_W-1:0]     cmd;
  logic [pida_pkg::WORD_W-1:0]    handle;
  logic [pida_pkg::WORD_W-1:0]    pick_code;

  modport source (output valid, cmd, handle, pick_code, input ready);
  modport sink   (input valid, cmd, handle, pick_code, output ready);
endinterface

interface pida_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pida_pkg::ID_OUT_W-1:0]  id_out;
  logic [pida_pkg::WORD_W-1:0]    color_word;
  logic [pida_pkg::WORD_W-1:0]    handle_out;
  logic [pida_pkg::STATUS_W-1:0]  status;

  modport source (output valid, id_out, color_word, handle_out, status, input ready);
  modport sink   (input valid, id_out, color_word, handle_out, status, output ready);
endinterface

FILE: src/pida_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module pida_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/pick_id_allocator_core.sv
// Pick id allocator top level: id table, LIFO free stack and response register.
// Depends on pida_pkg, pida_ifs (pida_req_if, pida_rsp_if) and pida_ram.
//
//  channel   dir  handshake      payload
//  in_req    in   valid/ready    cmd, handle, pick_code
//  out_rsp   out  valid/ready    id_out, color_word, handle_out, status
//
// Each request is handled in two steps: the accept edge launches reads of the
// slot table and of the free stack top, the next edge does the update and loads
// the response register, as both RAMs have registered read ports.
// A new request is taken in the idle state once the response register is free
// or leaving. rst_n (synchronous, active low) clears counts and control; the
// RAMs keep their contents and need no clearing, as only slots below the fresh
// count are ever used and each of those has been written.
module pick_id_allocator_core #(
  parameter int MAX_IDS     = pida_pkg::MAX_IDS_DEF,
  parameter int HANDLE_BITS = pida_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pida_req_if.sink    in_req,
  pida_rsp_if.source  out_rsp
);

  localparam int ID_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W  = $clog2(MAX_IDS + 1);
  localparam int IDC_W  = pida_pkg::CODE_ID_BITS;
  localparam int WORD_W = pida_pkg::WORD_W;
  localparam int OUT_W  = pida_pkg::ID_OUT_W;
  localparam int SLOT_W = HANDLE_BITS + 1;   // valid bit above the handle

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                         state_r;
  logic [pida_pkg::CMD_W-1:0]     cmd_r;
  logic [WORD_W-1:0]              handle_r;
  logic [IDC_W-1:0]               id_r;
  logic [CNT_W-1:0]               free_count_r, free_count_nxt;
  logic [CNT_W-1:0]               fresh_count_r, fresh_count_nxt;

  logic                           out_valid_r;
  logic [OUT_W-1:0]               id_out_r, id_out_nxt;
  logic [WORD_W-1:0]              color_r, color_nxt;
  logic [WORD_W-1:0]              hout_r, hout_nxt;
  logic [pida_pkg::STATUS_W-1:0]  status_r, status_nxt;

  logic                           accept;

  // slot table
  logic                           slot_we;
  logic [ID_W-1:0]                slot_waddr;
  logic [SLOT_W-1:0]              slot_wdata;
  logic [SLOT_W-1:0]              slot_rdata;

  // free stack
  logic                           stk_we;
  logic [ID_W-1:0]                stk_waddr;
  logic [ID_W-1:0]                stk_wdata;
  logic [ID_W-1:0]                stk_raddr;
  logic [ID_W-1:0]                stk_rdata;

  logic                           in_range;
  logic [ID_W-1:0]                got;
  logic [63:0]                    hnd_wide;
  logic [63:0]                    rd_wide;

  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  // top of stack; only used when the stack is not empty
  assign stk_raddr = ID_W'(free_count_r - CNT_W'(1));

  pida_ram #(.DEPTH(MAX_IDS), .WIDTH(SLOT_W)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (in_req.pick_code[ID_W-1:0]),
    .rdata (slot_rdata)
  );

  pida_ram #(.DEPTH(MAX_IDS), .WIDTH(ID_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // handle masked/extended to the stored width, and stored handle widened back
  always_comb begin
    hnd_wide = {32'd0, handle_r};
    rd_wide  = '0;
    rd_wide[HANDLE_BITS-1:0] = slot_rdata[HANDLE_BITS-1:0];
  end

  assign in_range = id_r < IDC_W'(fresh_count_r);

  // update for the request held in EXEC
  always_comb begin
    free_count_nxt  = free_count_r;
    fresh_count_nxt = fresh_count_r;
    id_out_nxt      = '0;
    color_nxt       = '0;
    hout_nxt        = '0;
    status_nxt      = pida_pkg::ST_OK;
    slot_we         = 1'b0;
    slot_waddr      = id_r[ID_W-1:0];
    slot_wdata      = '0;
    stk_we          = 1'b0;
    stk_waddr       = ID_W'(free_count_r);
    stk_wdata       = id_r[ID_W-1:0];
    got             = stk_rdata;

    if (state_r == S_EXEC) begin
      unique case (cmd_r)
        pida_pkg::CMD_ALLOC: begin
          priority if (free_count_r != '0) begin
            got            = stk_rdata;
            free_count_nxt = free_count_r - CNT_W'(1);
          end else if (fresh_count_r < CNT_W'(MAX_IDS)) begin
            got             = ID_W'(fresh_count_r);
            fresh_count_nxt = fresh_count_r + CNT_W'(1);
          end else begin
            status_nxt = pida_pkg::ST_FULL;
          end
          if (status_nxt == pida_pkg::ST_OK) begin
            slot_we    = 1'b1;
            slot_waddr = got;
            slot_wdata = {1'b1, hnd_wide[HANDLE_BITS-1:0]};
            id_out_nxt = OUT_W'(got);
            color_nxt  = pida_pkg::COLOR_TOP | WORD_W'(got);
          end
        end
        pida_pkg::CMD_RELEASE: begin
          id_out_nxt = id_r[OUT_W-1:0];
          if (!in_range) begin
            status_nxt = pida_pkg::ST_RANGE;
          end else if (slot_rdata[HANDLE_BITS]) begin
            slot_we = 1'b1;
            // top fresh id shrinks the fresh range, others go on the stack
            if (id_r == IDC_W'(fresh_count_r - CNT_W'(1))) begin
              fresh_count_nxt = fresh_count_r - CNT_W'(1);
            end else if (free_count_r < CNT_W'(MAX_IDS)) begin
              stk_we         = 1'b1;
              free_count_nxt = free_count_r + CNT_W'(1);
            end
          end
        end
        pida_pkg::CMD_LOOKUP: begin
          id_out_nxt = id_r[OUT_W-1:0];
          if (!in_range) begin
            status_nxt = pida_pkg::ST_RANGE;
          end else if (slot_rdata[HANDLE_BITS]) begin
            hout_nxt = rd_wide[WORD_W-1:0];
          end
        end
        default: begin
          // unused code: all-zero response
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      free_count_r  <= '0;
      fresh_count_r <= '0;
    end else begin
      if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= in_req.cmd;
            handle_r <= in_req.handle;
            id_r     <= in_req.pick_code[IDC_W-1:0];
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          free_count_r  <= free_count_nxt;
          fresh_count_r <= fresh_count_nxt;
          id_out_r      <= id_out_nxt;
          color_r       <= color_nxt;
          hout_r        <= hout_nxt;
          status_r      <= status_nxt;
          out_valid_r   <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.id_out     = id_out_r;
  assign out_rsp.color_word = color_r;
  assign out_rsp.handle_out = hout_r;
  assign out_rsp.status     = status_r;

endmodule
